### rtl/apra_pkg.sv
// Package: shared types and constants of the aligned page range allocator.
`timescale 1ns / 1ps
package apra_pkg;

  // Page numbers carry one bit beyond the largest page index
  localparam int unsigned PG_W = 21;
  localparam int unsigned OFS_W = 32;
  localparam int unsigned WORD_W = 64;
  localparam int unsigned PAGE_SHIFT = 12;
  localparam int unsigned CFG_IDX_W = 2;
  // Coarse alignment step in pages (power of two)
  localparam int unsigned ALIGN_PAGES = 64;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_NO_ROOM = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TOTAL_PAGES = 2'd0,
    CFG_FLOOR_PAGE  = 2'd1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ALIGN,
    S_CHECK,
    S_SCAN_RD,
    S_SCAN_EV,
    S_MARK_RD,
    S_MARK_WR,
    S_DONE
  } state_e;

  typedef struct packed {
    logic                  mode;
    logic [PG_W-1:0]       page_count;
    logic                  want_aligned;
    logic [OFS_W-1:0]      release_offset;
    logic [OFS_W-1:0]      release_bytes;
  } req_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [PG_W-2:0]       start_page;
    logic [OFS_W-1:0]      granted_offset;
  } rsp_t;

  // Control between sequencer and alignment unit
  typedef struct packed {
    logic            start;
    logic [PG_W-1:0] x;
  } align_req_t;

  typedef struct packed {
    logic            done;
    logic [PG_W-1:0] y;
  } align_rsp_t;

endpackage

### rtl/apra_if.sv
// Interfaces: request and response channels with valid/ready handshake.
`timescale 1ns / 1ps
interface apra_req_if;
  logic               valid;
  logic               ready;
  apra_pkg::req_t     req;
  modport source (output valid, output req, input ready);
  modport sink (input valid, input req, output ready);
endinterface

interface apra_rsp_if;
  logic               valid;
  logic               ready;
  apra_pkg::rsp_t     rsp;
  modport source (output valid, output rsp, input ready);
  modport sink (input valid, input rsp, output ready);
endinterface

### rtl/apra_ram.sv
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
module apra_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16384
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  output logic [WIDTH-1:0]                         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;
endmodule

### rtl/apra_align.sv
// Alignment unit: rounds a page number down to a multiple of ALIGN_PAGES; the result is registered.
`timescale 1ns / 1ps
module apra_align (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  apra_pkg::align_req_t  req_i,
  output apra_pkg::align_rsp_t  rsp_o
);
  logic                      done_q, done_d;
  logic [apra_pkg::PG_W-1:0] y_q, y_d;

  // Clear the low bits below the alignment step
  always_comb begin
    done_d = req_i.start;
    y_d    = y_q;
    if (req_i.start) begin
      y_d = req_i.x & ~apra_pkg::PG_W'(apra_pkg::ALIGN_PAGES - 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    y_q <= y_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.y    = y_q;
endmodule

### rtl/apra_word.sv
// Word unit: builds the page mask of one map word and finds its highest set bit.
`timescale 1ns / 1ps
module apra_word #(
  parameter int unsigned AW = 14
) (
  input  logic [AW-1:0]                 w_i,
  input  logic [apra_pkg::PG_W-1:0]     lo_i,
  input  logic [apra_pkg::PG_W-1:0]     hi_i,
  input  logic [apra_pkg::WORD_W-1:0]   data_i,
  output logic [apra_pkg::WORD_W-1:0]   mask_o,
  output logic                          hit_o,
  output logic [5:0]                    top_o
);
  logic [apra_pkg::PG_W-1:0]   base;
  logic [apra_pkg::PG_W-1:0]   lo_d, hi_d;
  logic [5:0]                  lo_bit;
  logic [apra_pkg::WORD_W-1:0] hi_mask, lo_mask, hits;

  assign base = apra_pkg::PG_W'({w_i, 6'b0});
  assign lo_d = lo_i - base;
  assign hi_d = hi_i - base;
  assign lo_bit = (lo_i > base) ? lo_d[5:0] : 6'd0;

  // Bits of the word inside [lo, hi)
  always_comb begin
    if (hi_d >= apra_pkg::PG_W'(apra_pkg::WORD_W)) begin
      hi_mask = '1;
    end else begin
      hi_mask = (64'd1 << hi_d[5:0]) - 64'd1;
    end
    lo_mask = ~((64'd1 << lo_bit) - 64'd1);
    mask_o  = hi_mask & lo_mask;
  end

  assign hits  = data_i & mask_o;
  assign hit_o = |hits;

  // Leading-one detect
  always_comb begin
    top_o = 6'd0;
    for (int i = 0; i < apra_pkg::WORD_W; i++) begin
      if (hits[i]) begin
        top_o = 6'(i);
      end
    end
  end
endmodule

### rtl/aligned_page_range_allocator.sv
// Aligned page range allocator: top level with sequencer, config and use-map memory.
// Allocate scans the use map word by word from the top down through the single map port,
//   restarting below a used page that it finds, then marks the run; release clears its pages.
//   One request at a time; ready is low until the response is queued.
// Reset (async, active low) runs a clearing pass over every word of the map;
//   requests wait, config writes are taken meanwhile.
`timescale 1ns / 1ps
module aligned_page_range_allocator #(
  parameter int unsigned MAX_PAGES   = 1048576
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [apra_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [apra_pkg::PG_W-1:0]            cfg_wdata_i,
  apra_req_if.sink                             req_i,
  apra_rsp_if.source                           rsp_o
);
  localparam int unsigned MAP_WORDS = (MAX_PAGES + 63) / 64;
  localparam int unsigned AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned PW = apra_pkg::PG_W;

  apra_pkg::state_e state_q, state_d;

  logic [PW-1:0]  total_q, floor_q, eff_total;
  logic [PW-1:0]  n_q, n_d, start_q, start_d, lo_q, lo_d, hi_q, hi_d;
  logic [AW-1:0]  w_q, w_d, clr_q, clr_d;
  logic           set_q, set_d, alloc_q, alloc_d, aligned_q, aligned_d;
  logic [1:0]     status_q, status_d;
  logic           out_v_q, out_v_d;
  apra_pkg::rsp_t rsp_q, rsp_d;

  apra_pkg::align_req_t align_req;
  apra_pkg::align_rsp_t align_rsp;

  logic                          ram_we;
  logic [AW-1:0]                 ram_addr;
  logic [apra_pkg::WORD_W-1:0]   ram_wdata, ram_rdata, word_mask;
  logic                          word_hit;
  logic [5:0]                    word_top;

  logic [PW-1:0]  rel_first;
  logic [PW-1:0]  rel_n;
  logic [PW:0]    rel_end, rel_end_c;
  logic [PW-1:0]  used_page, hi_minus;
  logic [apra_pkg::OFS_W:0] rel_sum;

  assign eff_total = (total_q > PW'(MAX_PAGES)) ? PW'(MAX_PAGES) : total_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= PW'(1048576);
      floor_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        apra_pkg::CFG_TOTAL_PAGES: total_q <= cfg_wdata_i;
        apra_pkg::CFG_FLOOR_PAGE:  floor_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Release range in pages, size rounded up without wrap
  assign rel_first = PW'(req_i.req.release_offset >> apra_pkg::PAGE_SHIFT);
  assign rel_sum   = {1'b0, req_i.req.release_bytes} + 33'd4095;
  assign rel_n     = PW'(rel_sum >> apra_pkg::PAGE_SHIFT);
  assign rel_end   = {1'b0, rel_first} + {1'b0, rel_n};
  assign rel_end_c = (rel_end > {1'b0, eff_total}) ? {1'b0, eff_total} : rel_end;

  assign used_page = PW'({w_q, word_top});
  assign hi_minus  = hi_q - PW'(1);

  apra_word #(.AW(AW)) u_word (
    .w_i    (w_q),
    .lo_i   (lo_q),
    .hi_i   (hi_q),
    .data_i (ram_rdata),
    .mask_o (word_mask),
    .hit_o  (word_hit),
    .top_o  (word_top)
  );

  apra_align u_align (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (align_req),
    .rsp_o  (align_rsp)
  );

  apra_ram #(.WIDTH(apra_pkg::WORD_W), .DEPTH(MAP_WORDS)) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // Word index of the last page of a run ending before the given page
  function automatic logic [AW-1:0] hi_d_word(input logic [PW-1:0] end_pg);
    logic [PW-1:0] last;
    last = end_pg - PW'(1);
    return last[AW+5:6];
  endfunction

  // Sequencer
  always_comb begin
    state_d   = state_q;
    n_d       = n_q;
    start_d   = start_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    w_d       = w_q;
    clr_d     = clr_q;
    set_d     = set_q;
    alloc_d   = alloc_q;
    aligned_d = aligned_q;
    status_d  = status_q;
    out_v_d   = out_v_q && !rsp_o.ready;
    rsp_d     = rsp_q;
    align_req = '0;
    ram_we    = 1'b0;
    ram_addr  = w_q;
    ram_wdata = set_q ? (ram_rdata | word_mask) : (ram_rdata & ~word_mask);

    case (state_q)
      apra_pkg::S_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == AW'(MAP_WORDS - 1)) begin
          state_d = apra_pkg::S_IDLE;
        end
      end
      apra_pkg::S_IDLE: begin
        if (req_i.valid) begin
          status_d = apra_pkg::ST_OK;
          if (req_i.req.mode) begin
            alloc_d = 1'b0;
            set_d   = 1'b0;
            lo_d    = rel_first;
            hi_d    = rel_end_c[PW-1:0];
            w_d     = rel_first[AW+5:6];
            state_d = ({1'b0, rel_first} < rel_end_c) ? apra_pkg::S_MARK_RD
                                                      : apra_pkg::S_DONE;
          end else begin
            alloc_d   = 1'b1;
            n_d       = req_i.req.page_count;
            aligned_d = req_i.req.want_aligned;
            if (req_i.req.page_count == '0 || req_i.req.page_count > eff_total) begin
              status_d = apra_pkg::ST_INVALID;
              state_d  = apra_pkg::S_DONE;
            end else if (req_i.req.want_aligned) begin
              align_req.start = 1'b1;
              align_req.x     = eff_total - req_i.req.page_count;
              state_d         = apra_pkg::S_ALIGN;
            end else begin
              start_d = eff_total - req_i.req.page_count;
              state_d = apra_pkg::S_CHECK;
            end
          end
        end
      end
      apra_pkg::S_ALIGN: begin
        if (align_rsp.done) begin
          start_d = align_rsp.y;
          state_d = apra_pkg::S_CHECK;
        end
      end
      apra_pkg::S_CHECK: begin
        if (start_q < floor_q) begin
          status_d = apra_pkg::ST_NO_ROOM;
          state_d  = apra_pkg::S_DONE;
        end else begin
          lo_d    = start_q;
          hi_d    = start_q + n_q;
          w_d     = hi_d_word(start_q + n_q);
          state_d = apra_pkg::S_SCAN_RD;
        end
      end
      apra_pkg::S_SCAN_RD: begin
        state_d = apra_pkg::S_SCAN_EV;
      end
      apra_pkg::S_SCAN_EV: begin
        if (word_hit) begin
          // Next candidate must end below the used page
          if (used_page < n_q) begin
            status_d = apra_pkg::ST_NO_ROOM;
            state_d  = apra_pkg::S_DONE;
          end else if (aligned_q) begin
            align_req.start = 1'b1;
            align_req.x     = used_page - n_q;
            state_d         = apra_pkg::S_ALIGN;
          end else begin
            start_d = used_page - n_q;
            state_d = apra_pkg::S_CHECK;
          end
        end else if (w_q == lo_q[AW+5:6]) begin
          set_d   = 1'b1;
          state_d = apra_pkg::S_MARK_RD;
        end else begin
          w_d     = w_q - 1'b1;
          state_d = apra_pkg::S_SCAN_RD;
        end
      end
      apra_pkg::S_MARK_RD: begin
        state_d = apra_pkg::S_MARK_WR;
      end
      apra_pkg::S_MARK_WR: begin
        ram_we = 1'b1;
        if (w_q == hi_minus[AW+5:6]) begin
          state_d = apra_pkg::S_DONE;
        end else begin
          w_d     = w_q + 1'b1;
          state_d = apra_pkg::S_MARK_RD;
        end
      end
      apra_pkg::S_DONE: begin
        if (!out_v_q || rsp_o.ready) begin
          out_v_d = 1'b1;
          rsp_d.status = status_q;
          if (alloc_q && status_q == apra_pkg::ST_OK) begin
            rsp_d.start_page     = start_q[PW-2:0];
            rsp_d.granted_offset = {start_q[PW-2:0], 12'b0};
          end else begin
            rsp_d.start_page     = '0;
            rsp_d.granted_offset = '0;
          end
          state_d = apra_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = apra_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= apra_pkg::S_CLEAR;
      clr_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q       <= n_d;
    start_q   <= start_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    w_q       <= w_d;
    set_q     <= set_d;
    alloc_q   <= alloc_d;
    aligned_q <= aligned_d;
    status_q  <= status_d;
    rsp_q     <= rsp_d;
  end

  assign req_i.ready = (state_q == apra_pkg::S_IDLE);
  assign rsp_o.valid = out_v_q;
  assign rsp_o.rsp   = rsp_q;

  // A refused request never reports a page
  a_no_grant_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.rsp.status != apra_pkg::ST_OK) |-> rsp_o.rsp.start_page == '0)
    else $error("refused request carries a start page");

  // Granted offset follows the start page
  a_offset_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> rsp_o.rsp.granted_offset == {rsp_o.rsp.start_page, 12'b0})
    else $error("granted offset does not match start page");

  // One request at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("ready stayed high after accepting a request");
endmodule

### tb/tb_aligned_page_range_allocator.sv
// Testbench: random and directed allocate/release requests checked against a page-map predictor.
`timescale 1ns / 1ps
module tb_aligned_page_range_allocator;

  localparam int unsigned MAX_PG   = 1048576;
  localparam int unsigned ALIGN_PG = 64;

  typedef enum logic [1:0] {OP_REQ, OP_CFG, OP_DRAIN} op_kind_e;
  typedef struct {
    op_kind_e                  kind;
    apra_pkg::req_t            req;
    apra_pkg::cfg_idx_e        idx;
    logic [apra_pkg::PG_W-1:0] val;
  } op_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we;
  apra_pkg::cfg_idx_e cfg_idx;
  logic [apra_pkg::PG_W-1:0] cfg_wdata;

  apra_req_if rq ();
  apra_rsp_if rs ();

  aligned_page_range_allocator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (rq),
    .rsp_o       (rs)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Pending stimulus and outstanding grants
  op_t            op_q[$];
  apra_pkg::rsp_t grant_q[$];
  int             errors = 0;

  // Page map predictor
  bit          page_used [0:MAX_PG-1];
  int unsigned pm_total = MAX_PG;
  int unsigned pm_floor = 0;

  function automatic int unsigned eff_total(int unsigned t);
    return (t > MAX_PG) ? MAX_PG : t;
  endfunction

  // Highest used page in [lo, hi)
  function automatic bit highest_used(int unsigned lo, int unsigned hi,
                                      output int unsigned at);
    longint p;
    at = 0;
    for (p = hi; p > lo; p--) begin
      if (page_used[p-1]) begin
        at = p - 1;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  task automatic predict_grant(input apra_pkg::req_t r);
    apra_pkg::rsp_t  res;
    int unsigned     tot, n, al, st, u, p;
    longint unsigned first, np, last;
    bit              done;
    res = '0;
    res.status = apra_pkg::ST_OK;
    tot = eff_total(pm_total);
    if (r.mode) begin
      first = r.release_offset >> 12;
      np = (longint'(r.release_bytes) + 4095) >> 12;
      last = first + np;
      if (last > tot) last = tot;
      for (longint q = first; q < last; q++) page_used[q] = 1'b0;
    end else begin
      n = r.page_count;
      al = r.want_aligned ? ALIGN_PG : 1;
      if (n == 0 || n > tot) begin
        res.status = apra_pkg::ST_INVALID;
      end else begin
        st = ((tot - n) / al) * al;
        done = 1'b0;
        while (!done) begin
          if (st < pm_floor) begin
            res.status = apra_pkg::ST_NO_ROOM;
            done = 1'b1;
          end else if (!highest_used(st, st + n, u)) begin
            for (p = st; p < st + n; p++) page_used[p] = 1'b1;
            res.start_page = st[apra_pkg::PG_W-2:0];
            res.granted_offset = st << apra_pkg::PAGE_SHIFT;
            done = 1'b1;
          end else if (u < n) begin
            res.status = apra_pkg::ST_NO_ROOM;
            done = 1'b1;
          end else begin
            st = ((u - n) / al) * al;
          end
        end
      end
    end
    grant_q.push_back(res);
  endtask

  function automatic int pick_gap(bit burst);
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 120);
  endfunction

  // Request driver
  int  drv_gap, drv_settle;
  bit  drv_burst, drv_valid_n, drv_we_n;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rq.valid   <= 1'b0;
      rq.req     <= '0;
      cfg_we     <= 1'b0;
      cfg_idx    <= apra_pkg::CFG_TOTAL_PAGES;
      cfg_wdata  <= '0;
      drv_gap    = 0;
      drv_settle = 0;
      drv_burst  = 1'b0;
    end else begin
      drv_we_n = 1'b0;
      if (rq.valid && rq.ready) predict_grant(rq.req);
      if (!(rq.valid && !rq.ready)) begin
        drv_valid_n = 1'b0;
        if (drv_gap > 0) begin
          drv_gap--;
        end else if (op_q.size() > 0) begin
          case (op_q[0].kind)
            OP_REQ: begin
              rq.req <= op_q[0].req;
              drv_valid_n = 1'b1;
              void'(op_q.pop_front());
              if ($urandom_range(0, 39) == 0) drv_burst = !drv_burst;
              drv_gap = pick_gap(drv_burst);
            end
            OP_CFG: begin
              drv_we_n = 1'b1;
              cfg_idx <= op_q[0].idx;
              cfg_wdata <= op_q[0].val;
              if (op_q[0].idx == apra_pkg::CFG_TOTAL_PAGES) pm_total = op_q[0].val;
              else pm_floor = op_q[0].val;
              void'(op_q.pop_front());
            end
            default: begin
              // hold off until every grant is back, then let the block settle
              if (grant_q.size() == 0) begin
                if (drv_settle >= 40) begin
                  drv_settle = 0;
                  void'(op_q.pop_front());
                end else begin
                  drv_settle++;
                end
              end
            end
          endcase
        end
        rq.valid <= drv_valid_n;
      end
      cfg_we <= drv_we_n;
    end
  end

  // Response monitor with random stalls
  int mon_gap;
  bit mon_burst;
  apra_pkg::rsp_t exp_r;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rs.ready  <= 1'b0;
      mon_gap   = 0;
      mon_burst = 1'b0;
    end else begin
      if (rs.valid && rs.ready) begin
        if (grant_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected response: %p", rs.rsp);
        end else begin
          exp_r = grant_q.pop_front();
          if (rs.rsp.status != exp_r.status || rs.rsp.start_page != exp_r.start_page ||
              rs.rsp.granted_offset != exp_r.granted_offset) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected st=%0d pg=%0d ofs=%h, got st=%0d pg=%0d ofs=%h",
                       exp_r.status, exp_r.start_page, exp_r.granted_offset,
                       rs.rsp.status, rs.rsp.start_page, rs.rsp.granted_offset);
          end
        end
      end
      if ($urandom_range(0, 49) == 0) mon_burst = !mon_burst;
      if (mon_gap > 0) begin
        mon_gap--;
        rs.ready <= 1'b0;
      end else begin
        rs.ready <= 1'b1;
        mon_gap = pick_gap(mon_burst);
      end
    end
  end

  // Stimulus builders
  int unsigned gen_total = MAX_PG;

  task automatic add_req(input bit rel, input int unsigned cnt, input bit al,
                         input logic [31:0] ofs, input logic [31:0] nbytes);
    op_t o;
    o = '{kind: OP_REQ, req: '0, idx: apra_pkg::CFG_TOTAL_PAGES, val: '0};
    o.req.mode = rel;
    o.req.page_count = cnt[apra_pkg::PG_W-1:0];
    o.req.want_aligned = al;
    o.req.release_offset = ofs;
    o.req.release_bytes = nbytes;
    op_q.push_back(o);
  endtask

  task automatic add_drain();
    op_t o;
    o = '{kind: OP_DRAIN, req: '0, idx: apra_pkg::CFG_TOTAL_PAGES, val: '0};
    op_q.push_back(o);
  endtask

  task automatic add_cfg(input int unsigned tot, input int unsigned flr);
    op_t o;
    add_drain();
    o = '{kind: OP_CFG, req: '0, idx: apra_pkg::CFG_TOTAL_PAGES,
          val: tot[apra_pkg::PG_W-1:0]};
    op_q.push_back(o);
    o.idx = apra_pkg::CFG_FLOOR_PAGE;
    o.val = flr[apra_pkg::PG_W-1:0];
    op_q.push_back(o);
    gen_total = eff_total(tot);
  endtask

  task automatic add_random();
    int unsigned r, t, lim;
    t = gen_total;
    r = $urandom_range(0, 99);
    lim = (t < 16) ? t : 16;
    if (r < 55)
      add_req(1'b0, $urandom_range(1, lim), $urandom_range(0, 1), $urandom, $urandom);
    else if (r < 60)
      add_req(1'b0, $urandom_range(1, t), $urandom_range(0, 1), $urandom, $urandom);
    else if (r < 64)
      add_req(1'b0, $urandom & 32'h1F_FFFF, $urandom_range(0, 1), $urandom, $urandom);
    else if (r < 68)
      add_req(1'b0, t + $urandom_range(0, 1), $urandom_range(0, 1), $urandom, $urandom);
    else if (r < 93)
      add_req(1'b1, $urandom, $urandom_range(0, 1),
              ($urandom_range(0, t - 1) << 12) + $urandom_range(0, 4095),
              $urandom_range(0, 48 * 4096));
    else
      add_req(1'b1, $urandom, $urandom_range(0, 1), $urandom, $urandom);
  endtask

  int unsigned ph_total [7] = '{512, 1, 4096, 2097151, 300, 128, 1000};
  int unsigned ph_floor [7] = '{0, 0, 100, 1048276, 1048576, 0, 37};
  int unsigned ph_items [7] = '{120, 10, 120, 60, 10, 120, 120};

  initial begin
    // Directed: reset config, count extremes, full map, release edges
    add_req(1'b0, 0, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_req(1'b0, 32'h1F_FFFF, 1'b1, 0, 0);
    add_req(1'b0, MAX_PG + 1, 1'b0, 0, 0);
    add_req(1'b0, 1, 1'b0, 0, 0);
    add_req(1'b0, 1, 1'b1, 0, 0);
    add_req(1'b0, 64, 1'b1, 0, 0);
    add_req(1'b0, 100, 1'b0, 0, 0);
    add_req(1'b1, 0, 1'b0, (MAX_PG - 1) << 12, 1);
    add_req(1'b1, 0, 1'b0, 32'h0, 32'h0);
    add_req(1'b1, 0, 1'b0, 32'hFFFF_F000, 32'hFFFF_FFFF);
    add_req(1'b1, 0, 1'b0, 32'h0, 32'hFFFF_FFFF);
    add_req(1'b0, MAX_PG, 1'b1, 0, 0);
    add_req(1'b1, 0, 1'b0, 32'h0, 32'hFFFF_FFFF);
    add_req(1'b0, 3, 1'b0, 0, 0);
    add_req(1'b1, 0, 1'b1, 32'hFFFF_EFFF, 32'h0000_1001);
    add_drain();

    // Random phases over several register settings
    for (int i = 0; i < 7; i++) begin
      add_cfg(ph_total[i], ph_floor[i]);
      if (ph_total[i] <= 512 && ph_floor[i] == 0)
        add_req(1'b0, eff_total(ph_total[i]), 1'b0, 0, 0);
      for (int k = 0; k < ph_items[i]; k++) begin
        add_random();
        if (k == ph_items[i] / 2) add_drain();
      end
    end
    add_drain();

    #1;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (op_q.size() > 0 || rq.valid || grant_q.size() > 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (errors == 0 && grant_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Run limit: well above a full map scan and mark for every request
  initial begin
    repeat (200_000_000) @(posedge clk_i);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
